FILE: design/text_command_line_decoder_unit_assert.svh
// assertion macros for the text command line decoder
// no dependencies; expects clk and rst_n in the including module
`ifndef TEXT_COMMAND_LINE_DECODER_UNIT_ASSERT_SVH
`define TEXT_COMMAND_LINE_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
// condition implies consequence in the same cycle
`define TCLD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcld assertion failed");
// condition implies consequence in the next cycle
`define TCLD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcld assertion failed");
`else
`define TCLD_ASSERT_NOW(lbl, ante, cons)
`define TCLD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: design/tcld_pkg.sv
// shared types, byte codes and keyword tables for the command line decoder
// no dependencies
`timescale 1ns / 1ps

package tcld_pkg;

    localparam int LINE_MAX_DEF = 1024;
    localparam int NUM_W        = 31;
    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    localparam int KEY_CNT    = 6;
    localparam int PREFIX_BIT = 5;
    localparam logic [2:0] PREFIX_LEN = 3'd7;

    // command codes reported with each line end or abort
    typedef enum logic [2:0] {
        CMD_NONE    = 3'd0,
        CMD_OFF     = 3'd1,
        CMD_STOP    = 3'd2,
        CMD_START   = 3'd3,
        CMD_SCALE_F = 3'd4,
        CMD_SCALE_C = 3'd5,
        CMD_PERIOD  = 3'd6,
        CMD_ABORT   = 3'd7
    } cmd_t;

    // number parser phase
    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_DIGITS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef struct packed {
        phase_t            phase;
        logic              negative;
        logic [NUM_W-1:0]  acc;
    } num_state_t;

    // byte codes
    localparam logic [7:0] CH_ETX   = 8'd3;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    // keyword text, right aligned, first character in the highest used byte
    localparam logic [55:0] KEY_TEXT [KEY_CNT] = '{
        56'("OFF"), 56'("STOP"), 56'("START"),
        56'("SCALE=F"), 56'("SCALE=C"), 56'("PERIOD=")
    };
    localparam logic [2:0] KEY_LEN [KEY_CNT] = '{
        3'd3, 3'd4, 3'd5, 3'd7, 3'd7, 3'd7
    };

    // character of keyword k at position pos (pos below the keyword length)
    function automatic logic [7:0] key_char(input int k, input logic [2:0] pos);
        logic [2:0] sh;
        sh = KEY_LEN[k] - pos - 3'd1;
        return KEY_TEXT[k][sh*8 +: 8];
    endfunction

endpackage

FILE: design/text_command_line_decoder_unit.sv
// top level of the text command line decoder: input register, line matcher,
// settings registers and result register; depends on tcld_pkg, tcld_number
// A line end or abort byte passes through the input register, and its report is loaded into the result register.
// Throughput: one byte per cycle while out_stall does not hold the result register,
// with the combinational match and multiply-by-ten accumulate between the input and result registers.
// Reset: period 1, running, Fahrenheit, not halted, empty line.
`timescale 1ns / 1ps
`include "text_command_line_decoder_unit_assert.svh"

module text_command_line_decoder_unit
    import tcld_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       data_byte,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       command_code,
    output logic [NUM_W-1:0] period_out,
    output logic             running_out,
    output logic             celsius_out
);

    localparam int POS_W = $clog2(LINE_MAX + 1);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(LINE_MAX);

    // input register
    logic             in_full_reg;
    logic [7:0]       byte_reg;

    // line and settings state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [KEY_CNT-1:0] cand_reg, cand_next;
    num_state_t         num_reg, num_next, num_step;
    logic [NUM_W-1:0]   period_reg, period_next;
    logic               running_reg, running_next;
    logic               celsius_reg, celsius_next;
    logic               halted_reg, halted_next;

    // result register
    logic               out_valid_reg;
    cmd_t               code_reg;
    logic [NUM_W-1:0]   period_out_reg;
    logic               running_out_reg;
    logic               celsius_out_reg;

    logic               advance;
    logic               proc;
    logic               res_load;
    cmd_t               res_code;

    // pipeline moves when the result register is free or being taken
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = in_full_reg && !advance;
    assign proc     = in_full_reg && advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_full_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= data_byte;
        end
    end

    // number parser step
    tcld_number u_number (
        .data_byte (byte_reg),
        .cur       (num_reg),
        .nxt       (num_step)
    );

    // byte processing: abort, line end or ordinary line byte
    always_comb
    begin
        pos_next     = pos_reg;
        cand_next    = cand_reg;
        num_next     = num_reg;
        period_next  = period_reg;
        running_next = running_reg;
        celsius_next = celsius_reg;
        halted_next  = halted_reg;
        res_load     = 1'b0;
        res_code     = CMD_NONE;

        if (proc && !halted_reg)
        begin
            if (byte_reg == CH_ETX)
            begin
                halted_next = 1'b1;
                res_load    = 1'b1;
                res_code    = CMD_ABORT;
            end
            else if (byte_reg == CH_LF || byte_reg == CH_CR)
            begin
                // match the finished line
                if (pos_reg != '0 && pos_reg < POS_LIMIT)
                begin
                    for (int k = 0; k < PREFIX_BIT; k++)
                    begin
                        if (res_code == CMD_NONE && cand_reg[k]
                            && pos_reg == POS_W'(KEY_LEN[k]))
                        begin
                            res_code = cmd_t'(3'(k + 1));
                        end
                    end
                    if (res_code == CMD_NONE && cand_reg[PREFIX_BIT]
                        && pos_reg >= POS_W'(PREFIX_LEN))
                    begin
                        res_code = CMD_PERIOD;
                    end
                end

                // apply the command
                unique case (res_code)
                    CMD_OFF:     halted_next  = 1'b1;
                    CMD_STOP:    running_next = 1'b0;
                    CMD_START:   running_next = 1'b1;
                    CMD_SCALE_F: celsius_next = 1'b0;
                    CMD_SCALE_C: celsius_next = 1'b1;
                    CMD_PERIOD:  period_next  = num_reg.negative ? '0 : num_reg.acc;
                    default:     period_next  = period_reg;
                endcase

                // fresh line
                pos_next  = '0;
                cand_next = '1;
                num_next  = '{phase: PH_SKIP, negative: 1'b0, acc: '0};
                res_load  = 1'b1;
            end
            else
            begin
                // drop keywords that no longer match
                for (int k = 0; k < KEY_CNT; k++)
                begin
                    if (pos_reg < POS_W'(KEY_LEN[k]))
                    begin
                        if (key_char(k, pos_reg[2:0]) != byte_reg)
                        begin
                            cand_next[k] = 1'b0;
                        end
                    end
                    else if (k != PREFIX_BIT)
                    begin
                        cand_next[k] = 1'b0;
                    end
                end
                if (pos_reg >= POS_W'(PREFIX_LEN))
                begin
                    num_next = num_step;
                end
                if (pos_reg < POS_LIMIT)
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    // line and settings registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            cand_reg    <= '1;
            num_reg     <= '{phase: PH_SKIP, negative: 1'b0, acc: '0};
            period_reg  <= NUM_W'(1);
            running_reg <= 1'b1;
            celsius_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            cand_reg    <= cand_next;
            num_reg     <= num_next;
            period_reg  <= period_next;
            running_reg <= running_next;
            celsius_reg <= celsius_next;
            halted_reg  <= halted_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= res_load || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            code_reg        <= res_code;
            period_out_reg  <= period_next;
            running_out_reg <= running_next;
            celsius_out_reg <= celsius_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign command_code = code_reg;
    assign period_out   = period_out_reg;
    assign running_out  = running_out_reg;
    assign celsius_out  = celsius_out_reg;

    // checks
    `TCLD_ASSERT_NEXT(a_halt_sticks, halted_reg, halted_reg)
    `TCLD_ASSERT_NEXT(a_off_abort_halts, res_load && (res_code == CMD_OFF || res_code == CMD_ABORT), halted_reg)
    `TCLD_ASSERT_NOW(a_pos_bounded, 1'b1, pos_reg <= POS_LIMIT)
    `TCLD_ASSERT_NOW(a_stall_needs_item, in_stall, in_full_reg)
    `TCLD_ASSERT_NOW(a_no_result_halted, halted_reg, !res_load)

endmodule

FILE: design/tcld_number.sv
// one byte step of the number parser after the period prefix
// depends on tcld_pkg
`timescale 1ns / 1ps

module tcld_number
    import tcld_pkg::*;
(
    input  logic [7:0]  data_byte,
    input  num_state_t  cur,
    output num_state_t  nxt
);

    localparam int SUM_W = NUM_W + 4;

    logic             digit;
    logic             blank;
    logic             sign;
    logic [SUM_W-1:0] times_ten;
    logic [SUM_W-1:0] sum;

    // class of the incoming byte
    assign digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
    assign blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB)
                || (data_byte == CH_VT) || (data_byte == CH_FF);
    assign sign  = (data_byte == CH_PLUS) || (data_byte == CH_MINUS);

    // accumulator times ten plus digit, as shift and add
    assign times_ten = SUM_W'({cur.acc, 3'b000}) + SUM_W'({cur.acc, 1'b0});
    assign sum       = times_ten + SUM_W'(data_byte[3:0]);

    // phase transitions with saturation at the field maximum
    always_comb
    begin
        nxt = cur;
        if (cur.phase != PH_DONE)
        begin
            if (digit)
            begin
                nxt.phase = PH_DIGITS;
                nxt.acc   = (sum > SUM_W'(NUM_MAX)) ? NUM_MAX : sum[NUM_W-1:0];
            end
            else if (cur.phase == PH_SKIP && blank)
            begin
                nxt = cur;
            end
            else if (cur.phase == PH_SKIP && sign)
            begin
                nxt.negative = (data_byte == CH_MINUS);
                nxt.phase    = PH_DIGITS;
            end
            else
            begin
                nxt.phase = PH_DONE;
            end
        end
    end

endmodule

FILE: tb/sv/tb.sv
// self-checking testbench for text_command_line_decoder_unit: random command lines,
// predicted reports compared field by field on the result channel
// depends on tcld_pkg and the decoder top level
`timescale 1ns / 1ps

module tb;
    import tcld_pkg::*;

    localparam int LINE_LIMIT     = LINE_MAX_DEF;
    localparam int PHASE_BYTES    = 88;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 20;

    typedef struct {
        cmd_t             code;
        logic [NUM_W-1:0] period;
        logic             running;
        logic             celsius;
    } report_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [7:0]       data_byte = 8'd0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [2:0]       command_code;
    logic [NUM_W-1:0] period_out;
    logic             running_out;
    logic             celsius_out;

    // byte stream still to send and reports still to arrive
    logic [7:0] pending_bytes [$];
    report_t    predicted_reports [$];
    int         bytes_queued = 0;
    int         failures = 0;
    int         quiet_cycles = 0;

    // idling controls, set per phase
    int   sender_idle_pct = 0;
    int   stall_pct = 0;
    logic hold_request = 1'b0;
    int   hold_left = 0;
    logic byte_taken = 1'b0;

    // decoder state mirrored by the predictor
    string            kw_text [KEY_CNT] = '{"OFF", "STOP", "START", "SCALE=F", "SCALE=C",
                                            "PERIOD="};
    logic [7:0]       blank_tab [4] = '{CH_SPACE, CH_TAB, CH_VT, CH_FF};
    int               line_pos = 0;
    logic [5:0]       live_keys = '1;
    phase_t           num_phase = PH_SKIP;
    logic             num_negative = 1'b0;
    logic [NUM_W-1:0] num_acc = '0;
    logic [NUM_W-1:0] period_setting = 31'd1;
    logic             running_setting = 1'b1;
    logic             celsius_setting = 1'b0;
    logic             decoder_halted = 1'b0;

    report_t          want;

    text_command_line_decoder_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .command_code (command_code),
        .period_out   (period_out),
        .running_out  (running_out),
        .celsius_out  (celsius_out)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // predictor: advance the decoder state by one byte, queue any report it causes
    function automatic void decode_byte(input logic [7:0] b);
        logic [31:0] acc_wide;
        logic [7:0]  key_ch;
        cmd_t        code;
        report_t     rep;
        if (decoder_halted)
            return;
        if (b == CH_ETX)
        begin
            decoder_halted = 1'b1;
            code = CMD_ABORT;
        end
        else if (b == CH_LF || b == CH_CR)
        begin
            // line end: exact keyword first, then the period prefix
            code = CMD_NONE;
            if (line_pos > 0 && line_pos < LINE_LIMIT)
            begin
                for (int k = 0; k < PREFIX_BIT; k++)
                begin
                    if (code == CMD_NONE && live_keys[k] && line_pos == kw_text[k].len())
                        code = cmd_t'(3'(k + 1));
                end
                if (code == CMD_NONE && live_keys[PREFIX_BIT] && line_pos >= PREFIX_LEN)
                    code = CMD_PERIOD;
            end
            case (code)
                CMD_OFF:     decoder_halted = 1'b1;
                CMD_STOP:    running_setting = 1'b0;
                CMD_START:   running_setting = 1'b1;
                CMD_SCALE_F: celsius_setting = 1'b0;
                CMD_SCALE_C: celsius_setting = 1'b1;
                CMD_PERIOD:  period_setting = num_negative ? '0 : num_acc;
                default:     ;
            endcase
            line_pos = 0;
            live_keys = '1;
            num_phase = PH_SKIP;
            num_negative = 1'b0;
            num_acc = '0;
        end
        else
        begin
            // knock out keywords that no longer match
            for (int k = 0; k < KEY_CNT; k++)
            begin
                if (line_pos < kw_text[k].len())
                begin
                    key_ch = kw_text[k][line_pos];
                    if (key_ch != b)
                        live_keys[k] = 1'b0;
                end
                else if (k != PREFIX_BIT)
                begin
                    live_keys[k] = 1'b0;
                end
            end
            // number after the period prefix, atoi style with saturation
            if (line_pos >= PREFIX_LEN && num_phase != PH_DONE)
            begin
                if (b >= CH_ZERO && b <= CH_NINE)
                begin
                    acc_wide = {1'b0, num_acc};
                    num_phase = PH_DIGITS;
                    if (acc_wide > ({1'b0, NUM_MAX} - (b - CH_ZERO)) / 32'd10)
                        num_acc = NUM_MAX;
                    else
                        num_acc = NUM_W'(acc_wide * 32'd10 + (b - CH_ZERO));
                end
                else if (!(num_phase == PH_SKIP &&
                           (b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF)))
                begin
                    if (num_phase == PH_SKIP && (b == CH_PLUS || b == CH_MINUS))
                    begin
                        num_negative = (b == CH_MINUS);
                        num_phase = PH_DIGITS;
                    end
                    else
                    begin
                        num_phase = PH_DONE;
                    end
                end
            end
            if (line_pos < LINE_LIMIT)
                line_pos++;
            return;
        end
        rep.code = code;
        rep.period = period_setting;
        rep.running = running_setting;
        rep.celsius = celsius_setting;
        predicted_reports.push_back(rep);
    endfunction

    // any byte that neither ends a line nor aborts
    function automatic logic [7:0] text_byte();
        logic [7:0] v;
        v = 8'($urandom_range(0, 255));
        while (v == CH_ETX || v == CH_LF || v == CH_CR)
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic queue_byte(input logic [7:0] v);
        pending_bytes.push_back(v);
        bytes_queued++;
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic push_end();
        queue_byte(($urandom_range(0, 1) == 1) ? CH_LF : CH_CR);
    endtask

    // one random line: mostly valid commands, some broken ones and noise
    task automatic queue_random_line();
        int         k;
        int         n;
        int         r;
        logic [7:0] ch;
        case ($urandom_range(0, 15))
            0, 1, 2, 3, 4:
                push_str(kw_text[$urandom_range(1, 4)]);
            5, 6, 7, 8:
            begin
                push_str("PERIOD=");
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) queue_byte(blank_tab[$urandom_range(0, 3)]);
                r = $urandom_range(0, 5);
                if (r == 0)
                    queue_byte(CH_PLUS);
                else if (r == 1)
                    queue_byte(CH_MINUS);
                r = $urandom_range(0, 9);
                if (r == 1)
                    push_str(($urandom_range(0, 1) == 1) ? "2147483647" : "2147483648");
                else if (r == 2)
                    repeat ($urandom_range(10, 14))
                        queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                else if (r != 0)
                    repeat ($urandom_range(1, 6))
                        queue_byte(CH_ZERO + 8'($urandom_range(0, 9)));
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 4)) queue_byte(text_byte());
            end
            9, 10, 11:
            begin
                // near miss on a keyword
                k = $urandom_range(0, KEY_CNT - 1);
                n = kw_text[k].len();
                case ($urandom_range(0, 3))
                    0:
                    begin
                        r = $urandom_range(1, n - 1);
                        for (int i = 0; i < r; i++)
                            queue_byte(kw_text[k][i]);
                    end
                    1:
                    begin
                        push_str(kw_text[k]);
                        queue_byte(text_byte());
                    end
                    2:
                    begin
                        r = $urandom_range(0, n - 1);
                        ch = text_byte();
                        while (ch == kw_text[k][r])
                            ch = text_byte();
                        for (int i = 0; i < n; i++)
                            queue_byte((i == r) ? ch : kw_text[k][i]);
                    end
                    default:
                    begin
                        queue_byte(blank_tab[$urandom_range(0, 3)]);
                        push_str(kw_text[k]);
                    end
                endcase
            end
            12, 13:
                repeat ($urandom_range(1, 20)) queue_byte(text_byte());
            default:
                ;
        endcase
        push_end();
    endtask

    // wait until every queued byte is sent and every predicted report has come back
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_bytes.size() != 0 || in_valid || predicted_reports.size() != 0);
    endtask

    // request capture on the input channel, feeding the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            decode_byte(data_byte);
            byte_taken = 1'b1;
        end
    end

    // driver: new request at the falling edge once the previous one was taken
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || byte_taken)
            begin
                if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    data_byte <= pending_bytes.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
            byte_taken = 1'b0;
        end
    end

    // receiver stall: random, or one long hold-off when requested
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: compare each report with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (predicted_reports.size() == 0)
            begin
                $error("unexpected report: command_code %0d period_out %0d", command_code,
                       period_out);
                failures++;
            end
            else
            begin
                want = predicted_reports.pop_front();
                if (command_code !== want.code)
                begin
                    $error("command_code: expected %0d, got %0d", want.code, command_code);
                    failures++;
                end
                if (period_out !== want.period)
                begin
                    $error("period_out: expected %0d, got %0d", want.period, period_out);
                    failures++;
                end
                if (running_out !== want.running)
                begin
                    $error("running_out: expected %0b, got %0b", want.running, running_out);
                    failures++;
                end
                if (celsius_out !== want.celsius)
                begin
                    $error("celsius_out: expected %0b, got %0b", want.celsius, celsius_out);
                    failures++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("TEST FAILED");
                    $finish;
                end
            end
        end
    end

    // stimulus sequence
    initial
    begin
        int send_idle_tab [4];
        int stall_tab [4];
        int target;
        send_idle_tab = '{0, 88, 0, 31};
        stall_tab = '{0, 0, 88, 31};

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty line, extreme bytes, stop, Celsius, negative period
        queue_byte(CH_LF);
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_CR);
        push_str("STOP");
        queue_byte(CH_CR);
        push_str("SCALE=C");
        queue_byte(CH_LF);
        push_str("PERIOD=-7");
        queue_byte(CH_LF);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            @(posedge clk);
            sender_idle_pct = send_idle_tab[ph];
            stall_pct = stall_tab[ph];
            if (ph == 0)
            begin
                // line exactly at the length limit counts as unknown
                push_str("PERIOD=42");
                repeat (LINE_LIMIT - 9) queue_byte(8'h78);
                queue_byte(CH_LF);
                wait_drained();
                // long receiver hold-off while bytes keep coming
                hold_request = 1'b1;
            end
            target = bytes_queued + PHASE_BYTES;
            while (bytes_queued < target)
                queue_random_line();
            wait_drained();
        end

        // halt by abort or by OFF, then bytes that must be ignored
        if ($urandom_range(0, 1) == 1)
        begin
            push_str("SCALE");
            queue_byte(CH_ETX);
        end
        else
        begin
            push_str("OFF");
            push_end();
        end
        push_str("START");
        queue_byte(CH_CR);
        queue_byte(CH_ETX);
        push_str("SCALE=C");
        queue_byte(CH_LF);
        repeat (8) queue_byte(text_byte());
        queue_byte(CH_LF);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (failures == 0 && predicted_reports.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+design
design/tcld_pkg.sv
design/tcld_number.sv
design/text_command_line_decoder_unit.sv
tb/sv/tb.sv
